### design/minv4_pkg.sv
package minv4_pkg;

	// Raw element width and the exact widths of cofactors and the determinant.
	localparam int ELEM_W = 32;
	localparam int COF_W  = 97;
	localparam int DET_W  = 130;
	localparam int FRAC_BITS_DEF = 16;

	// Column of the 3x3 minor used by factor f of determinant term t (the row is f).
	function automatic logic [1:0] term_col(input logic [2:0] t, input logic [1:0] f);
		logic [1:0] col;
		col = 2'd0;
		case (t)
			3'd0: col = f;
			3'd1: col = (f == 2'd0) ? 2'd1 : (f == 2'd1) ? 2'd2 : 2'd0;
			3'd2: col = (f == 2'd0) ? 2'd2 : (f == 2'd1) ? 2'd0 : 2'd1;
			3'd3: col = (f == 2'd0) ? 2'd2 : (f == 2'd1) ? 2'd1 : 2'd0;
			3'd4: col = (f == 2'd0) ? 2'd1 : (f == 2'd1) ? 2'd0 : 2'd2;
			3'd5: col = (f == 2'd0) ? 2'd0 : (f == 2'd1) ? 2'd2 : 2'd1;
			default: col = 2'd0;
		endcase
		return col;
	endfunction

	// Element address of factor f of term t in the minor that drops row r and column c.
	function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c,
			input logic [2:0] t, input logic [1:0] f);
		logic [1:0] mc;
		logic [1:0] row;
		logic [1:0] col;
		mc  = term_col(t, f);
		row = (f >= r) ? f + 2'd1 : f;
		col = (mc >= c) ? mc + 2'd1 : mc;
		return {row, col};
	endfunction

endpackage

### design/matrix_inverse_4x4_core.sv
// After the sixteenth element the block forms the cofactors, then the determinant, then each
// result by division in the restoring divider, one matrix at a time; inputs are not taken
// until the last result is delivered.
// The cost is set by the bit-serial shared multiplier and the restoring divider.
// Reset (arst_n low, asynchronous) clears the sequencer and the load count.
module matrix_inverse_4x4_core #(
	parameter int FRAC_BITS = minv4_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] element_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] inverse_value,
	output logic        singular,
	output logic        last_result
);

	localparam int CW = minv4_pkg::COF_W;
	localparam int DW = minv4_pkg::DET_W;

	typedef enum logic [10:0] {
		S_LOAD = 11'b00000000001,
		S_RDA  = 11'b00000000010,
		S_M1   = 11'b00000000100,
		S_W1   = 11'b00000001000,
		S_M2   = 11'b00000010000,
		S_W2   = 11'b00000100000,
		S_DM   = 11'b00001000000,
		S_DW   = 11'b00010000000,
		S_DIVS = 11'b00100000000,
		S_DIVW = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t        state_q;
	logic [3:0]    load_q;
	logic [3:0]    rc_q;
	logic [2:0]    term_q;
	logic [1:0]    dc_q;
	logic [3:0]    k_q;
	logic [31:0]   store_q [16];
	logic [CW-1:0] cof_q [16];
	logic [CW-1:0] acc_q;
	logic [DW-1:0] det_q;
	logic [31:0]   ta_q;
	logic [31:0]   out_val_q;
	logic          out_sing_q;

	logic          mul_start;
	logic [DW-1:0] mul_x;
	logic [31:0]   mul_y;
	logic          mul_done;
	logic [DW-1:0] mul_p;
	logic          div_start;
	logic          div_done;
	logic [31:0]   div_q;
	logic [3:0]    addr_a;
	logic [3:0]    addr_b;
	logic [3:0]    addr_c;
	logic          sub_term;
	logic [CW-1:0] acc_next;
	logic [CW-1:0] cof_sel;
	logic [3:0]    cof_addr;

	// Addresses of the three factors of the current determinant term.
	assign addr_a = minv4_pkg::elem_addr(rc_q[3:2], rc_q[1:0], term_q, 2'd0);
	assign addr_b = minv4_pkg::elem_addr(rc_q[3:2], rc_q[1:0], term_q, 2'd1);
	assign addr_c = minv4_pkg::elem_addr(rc_q[3:2], rc_q[1:0], term_q, 2'd2);

	// Term sign combined with the checkerboard sign of the cofactor.
	assign sub_term = (term_q >= 3'd3) ^ rc_q[2] ^ rc_q[0];
	assign acc_next = sub_term ? acc_q - mul_p[CW-1:0] : acc_q + mul_p[CW-1:0];

	// Cofactor read: first row for the determinant, transposed order for results.
	assign cof_addr = (state_q == S_DM) ? {2'd0, dc_q} : {k_q[1:0], k_q[3:2]};
	assign cof_sel  = cof_q[cof_addr];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_start = 1'b0;
		mul_x     = mul_p;
		mul_y     = store_q[addr_c];
		case (state_q)
			S_M1: begin
				mul_start = 1'b1;
				mul_x     = {{(DW-32){ta_q[31]}}, ta_q};
				mul_y     = store_q[addr_b];
			end
			S_M2: begin
				mul_start = 1'b1;
			end
			S_DM: begin
				mul_start = 1'b1;
				mul_x     = {{(DW-CW){cof_sel[CW-1]}}, cof_sel};
				mul_y     = store_q[{2'd0, dc_q}];
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_DIVS) && (det_q != '0);

	minv4_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.p      (mul_p)
	);

	minv4_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cof_sel),
		.den    (det_q),
		.done   (div_done),
		.quot   (div_q)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			load_q  <= 4'd0;
			rc_q    <= 4'd0;
			term_q  <= 3'd0;
			dc_q    <= 2'd0;
			k_q     <= 4'd0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						load_q <= load_q + 4'd1;
						if (load_q == 4'd15) begin
							rc_q    <= 4'd0;
							term_q  <= 3'd0;
							state_q <= S_RDA;
						end
					end
				end
				S_RDA: state_q <= S_M1;
				S_M1:  state_q <= S_W1;
				S_W1: begin
					if (mul_done) begin
						state_q <= S_M2;
					end
				end
				S_M2: state_q <= S_W2;
				S_W2: begin
					if (mul_done) begin
						if (term_q == 3'd5) begin
							term_q <= 3'd0;
							rc_q   <= rc_q + 4'd1;
							if (rc_q == 4'd15) begin
								dc_q    <= 2'd0;
								state_q <= S_DM;
							end else begin
								state_q <= S_RDA;
							end
						end else begin
							term_q  <= term_q + 3'd1;
							state_q <= S_RDA;
						end
					end
				end
				S_DM: state_q <= S_DW;
				S_DW: begin
					if (mul_done) begin
						dc_q <= dc_q + 2'd1;
						if (dc_q == 2'd3) begin
							k_q     <= 4'd0;
							state_q <= S_DIVS;
						end else begin
							state_q <= S_DM;
						end
					end
				end
				S_DIVS: state_q <= (det_q == '0) ? S_OUT : S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						k_q <= k_q + 4'd1;
						state_q <= (k_q == 4'd15) ? S_LOAD : S_DIVS;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Element store, accumulators and output register.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && in_valid) begin
			store_q[load_q] <= element_value;
			acc_q           <= '0;
			det_q           <= '0;
		end
		if (state_q == S_RDA) begin
			ta_q <= store_q[addr_a];
		end
		if (state_q == S_W2 && mul_done) begin
			if (term_q == 3'd5) begin
				cof_q[rc_q] <= acc_next;
				acc_q       <= '0;
			end else begin
				acc_q <= acc_next;
			end
		end
		if (state_q == S_DW && mul_done) begin
			det_q <= det_q + mul_p;
		end
		if (state_q == S_DIVS) begin
			out_val_q  <= 32'd0;
			out_sing_q <= (det_q == '0);
		end
		if (state_q == S_DIVW && div_done) begin
			out_val_q <= div_q;
		end
	end

	assign in_ready      = (state_q == S_LOAD);
	assign out_valid     = (state_q == S_OUT);
	assign inverse_value = out_val_q;
	assign singular      = out_sing_q;
	assign last_result   = (k_q == 4'd15);

endmodule

### design/minv4_mul.sv
module minv4_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [minv4_pkg::DET_W-1:0]       x,
	input  logic [minv4_pkg::ELEM_W-1:0]      y,
	output logic                              done,
	output logic [minv4_pkg::DET_W-1:0]       p
);

	localparam int DW = minv4_pkg::DET_W;

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [DW-1:0] x_q;
	logic [DW-1:0] acc_q;
	logic [minv4_pkg::ELEM_W-1:0] y_q;
	logic [DW-1:0] term;
	logic [DW-1:0] sum;

	// One partial product per cycle; the sign bit of y carries negative weight.
	assign term = y_q[0] ? x_q : '0;
	assign sum  = (cnt_q == 5'd31) ? acc_q - term : acc_q + term;

	// Control of the shift-add sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[DW-2:0], 1'b0};
			y_q   <= {1'b0, y_q[minv4_pkg::ELEM_W-1:1]};
			acc_q <= sum;
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

### design/minv4_div.sv
module minv4_div #(
	parameter int FRAC_BITS = minv4_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [minv4_pkg::COF_W-1:0]      num,
	input  logic [minv4_pkg::DET_W-1:0]      den,
	output logic                             done,
	output logic [minv4_pkg::ELEM_W-1:0]     quot
);

	localparam int CW    = minv4_pkg::COF_W;
	localparam int DW    = minv4_pkg::DET_W;
	localparam int NW    = CW + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(NW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    n_q;
	logic [DW-1:0]    d_q;
	logic [DW-1:0]    rem_q;
	logic [32:0]      q_q;
	logic             ovf_q;
	logic             neg_q;
	logic [CW-1:0]    num_mag;
	logic [DW-1:0]    den_mag;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             ge;

	// Magnitudes of the operands; the numerator is scaled by two fraction widths.
	assign num_mag = num[CW-1] ? CW'(-num) : num;
	assign den_mag = den[DW-1] ? DW'(-den) : den;

	// One restoring step per cycle.
	assign rem_sh  = {rem_q, n_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};
	assign ge      = !rem_sub[DW];

	// Control of the division sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, quotient and overflow registers.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {num_mag, {(2 * FRAC_BITS){1'b0}}};
			d_q   <= den_mag;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= num[CW-1] ^ den[DW-1];
		end else if (busy_q) begin
			n_q   <= {n_q[NW-2:0], 1'b0};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			q_q   <= {q_q[31:0], ge};
			ovf_q <= ovf_q | q_q[32];
		end
	end

	// Sign and saturation of the final quotient.
	always_comb begin
		if (!neg_q) begin
			quot = (ovf_q || q_q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_q[31:0];
		end else begin
			quot = (ovf_q || q_q > 33'h080000000) ? 32'h80000000 : 32'd0 - q_q[31:0];
		end
	end

	assign done = done_q;

endmodule

### bench/matrix_inverse_4x4_core_tb.sv
`timescale 1ns / 100ps

module matrix_inverse_4x4_core_tb;

	localparam int FRAC_BITS = minv4_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM_MATRICES = 30;

	typedef logic signed [199:0] exact_t;

	typedef struct {
		logic [31:0] value;
		logic        singular;
		logic        last;
	} inverse_elem_t;

	// Tracks the loaded matrix, computes its exact inverse and checks every result.
	class inverse_scoreboard;
		logic signed [31:0] matrix [16];
		int unsigned        loaded;
		inverse_elem_t      expected_q [$];
		int unsigned        mismatches;
		int unsigned        results_seen;
		int unsigned        singular_seen;
		int unsigned        saturated_seen;

		function new();
			loaded = 0;
			mismatches = 0;
			results_seen = 0;
			singular_seen = 0;
			saturated_seen = 0;
		endfunction

		// Determinant of the 3x3 minor that drops row r and column c.
		function exact_t minor_det(int r, int c);
			exact_t m [9];
			int n;
			n = 0;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					if (i != r && j != c) begin
						m[n] = matrix[i*4+j];
						n++;
					end
			return m[0]*m[4]*m[8] + m[1]*m[5]*m[6] + m[2]*m[3]*m[7]
				- m[2]*m[4]*m[6] - m[1]*m[3]*m[8] - m[0]*m[5]*m[7];
		endfunction

		function void note_input(logic [31:0] v);
			exact_t cof [16];
			exact_t det;
			exact_t num;
			exact_t quo;
			exact_t term;
			inverse_elem_t e;
			matrix[loaded] = v;
			loaded = (loaded + 1) % 16;
			if (loaded != 0)
				return;
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++) begin
					cof[r*4+c] = minor_det(r, c);
					if ((r + c) % 2 == 1)
						cof[r*4+c] = -cof[r*4+c];
				end
			det = 0;
			for (int c = 0; c < 4; c++) begin
				term = matrix[c];
				det = det + term * cof[c];
			end
			for (int k = 0; k < 16; k++) begin
				e.singular = (det == 0);
				e.last = (k == 15);
				e.value = '0;
				if (det != 0) begin
					num = cof[(k%4)*4 + k/4] <<< (2*FRAC_BITS);
					quo = num / det;
					if (quo > exact_t'(64'sd2147483647))
						e.value = 32'h7FFF_FFFF;
					else if (quo < -exact_t'(64'sd2147483648))
						e.value = 32'h8000_0000;
					else
						e.value = quo[31:0];
				end
				expected_q.push_back(e);
			end
		endfunction

		function void check_result(logic [31:0] v, logic s, logic l);
			inverse_elem_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result value=%h singular=%b last=%b", v, s, l);
				return;
			end
			e = expected_q.pop_front();
			if (e.singular)
				singular_seen++;
			if (e.value == 32'h7FFF_FFFF || e.value == 32'h8000_0000)
				saturated_seen++;
			if (v !== e.value || s !== e.singular || l !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d expected value=%h singular=%b last=%b, got %h %b %b",
						results_seen, e.value, e.singular, e.last, v, s, l);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] element_value;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] inverse_value;
	logic        singular;
	logic        last_result;

	inverse_scoreboard sb;
	bit                in_burst;
	bit                out_burst;
	int unsigned       matrices_sent;

	matrix_inverse_4x4_core #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.element_value(element_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.inverse_value(inverse_value),
		.singular(singular),
		.last_result(last_result)
	);

	always #5 clk = ~clk;

	// Sends one element; the wait before it is drawn fresh unless a burst is running.
	task automatic send_element(logic [31:0] v);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(v);
	endtask

	task automatic send_matrix(logic [31:0] m [16]);
		in_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < 16; i++)
			send_element(m[i]);
		matrices_sent++;
	endtask

	// Element drawn from one of several ranges: tiny, moderate, full width, extremes.
	function automatic logic [31:0] draw_element(int style);
		case (style)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
			2: return 32'($signed($urandom_range(0, 6)) - 3);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	// Result side: stalls drawn per result unless a burst is running, checked on every accepted transaction.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = out_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_result(inverse_value, singular, last_result);
			if (last_result)
				out_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Main sequence: directed matrices, then random ones, then drain and report.
	initial begin
		logic [31:0] m [16];
		int style;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		element_value = '0;
		in_burst = 0;
		out_burst = 0;
		matrices_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Diagonal of two tiny and two extreme entries: the inverse saturates both ways.
		for (int i = 0; i < 16; i++)
			m[i] = '0;
		m[0] = 32'd1;
		m[5] = 32'hFFFF_FFFF;
		m[10] = 32'h7FFF_FFFF;
		m[15] = 32'h8000_0000;
		send_matrix(m);

		// Repeated rows of extremes: a singular matrix.
		for (int i = 0; i < 16; i++)
			m[i] = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		send_matrix(m);

		// Identity in fixed point.
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? 32'(1 << FRAC_BITS) : 32'd0;
		send_matrix(m);

		for (int n = 0; n < N_RANDOM_MATRICES; n++) begin
			style = $urandom_range(0, 3);
			for (int i = 0; i < 16; i++)
				m[i] = draw_element(style);
			// Now and then copy one row onto another so that the matrix is singular.
			if ($urandom_range(0, 5) == 0)
				for (int j = 0; j < 4; j++)
					m[12+j] = m[4+j];
			send_matrix(m);
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d matrices; checked %0d results (%0d singular, %0d saturated).",
			matrices_sent, sb.results_seen, sb.singular_seen, sb.saturated_seen);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("Mismatches: %0d, results still expected: %0d",
				sb.mismatches, sb.expected_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end

	// Run limit, several times the slowest correct run.
	initial begin
		#40_000_000;
		$display("Timeout waiting for the block");
		$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
design/minv4_pkg.sv
design/minv4_mul.sv
design/minv4_div.sv
design/matrix_inverse_4x4_core.sv
bench/matrix_inverse_4x4_core_tb.sv
